FILE: src/pbr_pkg.sv
// Package for the PackBits run-length encoder: constants, item types and
// the control structs passed between the sequencer, the cell chain and the packer.
// No dependencies.
package pbr_pkg;

    // Longest run or literal group carried by one header byte
    localparam int MAX_BLOCK  = 128;
    localparam int BYTE_W     = 8;
    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = WORD_BYTES * BYTE_W;
    localparam int LANE_W     = 3;               // byte lane inside a word
    localparam int CNT_W      = 8;               // literal count and run length
    localparam int KCNT_W     = 4;               // bytes in a word, 0..8
    localparam int TOT_W      = KCNT_W + 1;      // bytes in packer plus new chunk
    localparam int NUM_CELLS  = (MAX_BLOCK + WORD_BYTES - 1) / WORD_BYTES;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic [KCNT_W-1:0] byte_count;
        logic              step_last;
        logic              stream_end;
    } t_out_item;

    // One command to the word packer: a chunk of bytes or a flush
    typedef struct packed {
        logic              valid;
        logic              flush;
        logic              end_flag;
        logic [KCNT_W-1:0] k;
        logic [WORD_W-1:0] data;
    } t_pk_cmd;

    // Control of the literal cell chain
    typedef struct packed {
        logic              shift_en;
        logic              wr_en;
        logic [CNT_W-1:0]  wr_idx;
        logic [BYTE_W-1:0] wr_byte;
    } t_chain_ctl;

endpackage

FILE: src/pbr_cell.sv
// One cell of the literal chain: a row of eight literal bytes.
// Depends on pbr_pkg.
module pbr_cell
    import pbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_shift_en,
    input  logic [WORD_W-1:0] i_shift_row,
    input  logic              i_wr_en,
    input  logic [LANE_W-1:0] i_wr_lane,
    input  logic [BYTE_W-1:0] i_wr_byte,
    output logic [WORD_W-1:0] o_row
);

    logic [WORD_W-1:0] r_row;

    // take the neighbor's row on a drain, else store a pushed byte
    always_ff @(posedge i_clk) begin
        if (i_shift_en) begin
            r_row <= i_shift_row;
        end else if (i_wr_en) begin
            r_row[i_wr_lane*BYTE_W +: BYTE_W] <= i_wr_byte;
        end
    end

    assign o_row = r_row;

endmodule

FILE: src/pbr_chain.sv
// Literal store as a chain of row cells; pushes land at the fill index,
// drains move every row one cell toward the head. Depends on pbr_pkg, pbr_cell.
module pbr_chain
    import pbr_pkg::*;
(
    input  logic              i_clk,
    input  t_chain_ctl        i_ctl,
    output logic [WORD_W-1:0] o_head
);

    logic [WORD_W-1:0] rows     [NUM_CELLS];
    logic [WORD_W-1:0] shift_in [NUM_CELLS];
    logic [NUM_CELLS-1:0] wr_sel;

    for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
        // tail cell pulls in nothing
        if (j == NUM_CELLS - 1) begin : g_tail
            assign shift_in[j] = '0;
        end else begin : g_mid
            assign shift_in[j] = rows[j+1];
        end

        assign wr_sel[j] = i_ctl.wr_en &&
            (i_ctl.wr_idx[CNT_W-1:LANE_W] == (CNT_W-LANE_W)'(j));

        pbr_cell u_cell (
            .i_clk       (i_clk),
            .i_shift_en  (i_ctl.shift_en),
            .i_shift_row (shift_in[j]),
            .i_wr_en     (wr_sel[j]),
            .i_wr_lane   (i_ctl.wr_idx[LANE_W-1:0]),
            .i_wr_byte   (i_ctl.wr_byte),
            .o_row       (rows[j])
        );
    end

    assign o_head = rows[0];

endmodule

FILE: src/pbr_packer.sv
// Word packer: gathers chunks of 1..8 bytes into 64-bit result words and
// holds the output register. Depends on pbr_pkg.
module pbr_packer
    import pbr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pk_cmd   i_cmd,
    output logic      o_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic [KCNT_W-1:0]   r_fill, n_fill;
    logic [WORD_W-1:0]   r_acc, n_acc;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic                slot_free;
    logic [WORD_W-1:0]   mask;
    logic [2*WORD_W-1:0] wide;
    logic [TOT_W-1:0]    total;

    assign slot_free = !r_out_valid || i_out_ready;
    assign o_ready   = slot_free;

    // lanes at and above k are zeroed before merging
    always_comb begin
        for (int l = 0; l < WORD_BYTES; l++) begin
            mask[l*BYTE_W +: BYTE_W] = (KCNT_W'(l) < i_cmd.k) ? '1 : '0;
        end
    end

    assign wide  = {{WORD_W{1'b0}}, r_acc}
                 | ({{WORD_W{1'b0}}, i_cmd.data & mask} << {r_fill, 3'b000});
    assign total = {1'b0, r_fill} + {1'b0, i_cmd.k};

    // a full word leaves only when more bytes spill past it, so the last
    // word of an item is always the one sent by the flush
    always_comb begin
        n_fill      = r_fill;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.valid && slot_free) begin
            if (i_cmd.flush) begin
                if (r_fill != '0) begin
                    n_out.out_word   = r_acc;
                    n_out.byte_count = r_fill;
                    n_out.step_last  = 1'b1;
                    n_out.stream_end = i_cmd.end_flag;
                    n_out_valid      = 1'b1;
                    n_fill           = '0;
                    n_acc            = '0;
                end
            end else if (total > TOT_W'(WORD_BYTES)) begin
                n_out.out_word   = wide[WORD_W-1:0];
                n_out.byte_count = KCNT_W'(WORD_BYTES);
                n_out.step_last  = 1'b0;
                n_out.stream_end = 1'b0;
                n_out_valid      = 1'b1;
                n_acc            = wide[2*WORD_W-1:WORD_W];
                n_fill           = KCNT_W'(total - TOT_W'(WORD_BYTES));
            end else begin
                n_acc  = wide[WORD_W-1:0];
                n_fill = total[KCNT_W-1:0];
            end
        end
    end

    // control and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_acc       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_fill      <= n_fill;
            r_acc       <= n_acc;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: src/packbits_run_length_encoder_unit.sv
// PackBits (ByteRun) encoder top level: item sequencer, literal cell chain
// and word packer. Depends on pbr_pkg, pbr_chain, pbr_packer.
// Bytes are taken only in the idle state, so a new byte is accepted only after
// the run, literal header and rows, pushed byte and flush that the last one
// produced have been handed to the word packer.
// Reset: synchronous, active low; clears the sequencer, counters and packer.
module packbits_run_length_encoder_unit
    import pbr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RUN   = 6'b000010,
        S_HDR   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_PUSH  = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    // next step of the item, in output order
    function automatic t_state pick(input logic run, input logic lit,
                                    input logic push, input logic run2);
        t_state st;
        priority if (run)  st = S_RUN;
        else if (lit)      st = S_HDR;
        else if (push)     st = S_PUSH;
        else if (run2)     st = S_RUN;
        else               st = S_FLUSH;
        return st;
    endfunction

    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_held, n_held;
    logic              r_held_v, n_held_v;
    logic [CNT_W-1:0]  r_run_len, n_run_len;
    logic              r_run_act, n_run_act;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_f_run, n_f_run;
    logic              r_f_lit, n_f_lit;
    logic              r_f_push, n_f_push;
    logic              r_f_run2, n_f_run2;
    logic [BYTE_W-1:0] r_er_val, n_er_val;
    logic [CNT_W-1:0]  r_er_len, n_er_len;
    logic [BYTE_W-1:0] r_p2, n_p2;
    logic              r_end, n_end;

    logic              in_eq;
    logic              run_go;
    logic              pk_ready;
    t_pk_cmd           pk_cmd;
    t_chain_ctl        ch_ctl;
    logic [WORD_W-1:0] ch_head;

    assign in_eq      = i_in_item.byte_in == r_held;
    assign run_go     = r_run_act && in_eq && (r_run_len < CNT_W'(MAX_BLOCK));
    assign o_in_ready = r_state == S_IDLE;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_held    = r_held;
        n_held_v  = r_held_v;
        n_run_len = r_run_len;
        n_run_act = r_run_act;
        n_cnt     = r_cnt;
        n_f_run   = r_f_run;
        n_f_lit   = r_f_lit;
        n_f_push  = r_f_push;
        n_f_run2  = r_f_run2;
        n_er_val  = r_er_val;
        n_er_len  = r_er_len;
        n_p2      = r_p2;
        n_end     = r_end;
        pk_cmd    = '0;
        ch_ctl    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // classify the byte against the held one
                    if (!r_held_v) begin
                        n_held   = i_in_item.byte_in;
                        n_held_v = 1'b1;
                    end else if (r_run_act) begin
                        if (run_go) begin
                            n_run_len = r_run_len + 1'b1;
                        end else begin
                            n_er_val  = r_held;
                            n_er_len  = r_run_len;
                            n_f_run   = 1'b1;
                            n_held    = i_in_item.byte_in;
                            n_run_act = 1'b0;
                            n_run_len = '0;
                        end
                    end else if (in_eq) begin
                        n_f_lit   = r_cnt != '0;
                        n_run_act = 1'b1;
                        n_run_len = CNT_W'(2);
                    end else begin
                        ch_ctl.wr_en   = 1'b1;
                        ch_ctl.wr_idx  = r_cnt;
                        ch_ctl.wr_byte = r_held;
                        n_cnt          = r_cnt + 1'b1;
                        n_f_lit        = (r_cnt + 1'b1) == CNT_W'(MAX_BLOCK);
                        n_held         = i_in_item.byte_in;
                    end
                    // end of stream: close what is open, back to reset state
                    if (i_in_item.last_byte) begin
                        if (n_run_act) begin
                            n_f_run2 = 1'b1;
                            n_er_val = n_held;
                            n_er_len = n_run_len;
                        end else begin
                            n_f_push = 1'b1;
                            n_p2     = i_in_item.byte_in;
                        end
                        n_held    = '0;
                        n_held_v  = 1'b0;
                        n_run_act = 1'b0;
                        n_run_len = '0;
                        n_end     = 1'b1;
                    end else begin
                        n_end = 1'b0;
                    end
                    n_state = pick(n_f_run, n_f_lit, n_f_push, n_f_run2);
                end
            end
            S_RUN: begin
                pk_cmd.valid = 1'b1;
                pk_cmd.k     = KCNT_W'(2);
                pk_cmd.data  = {{(WORD_W-2*BYTE_W){1'b0}}, r_er_val,
                                BYTE_W'(1) - r_er_len};
                if (pk_ready) begin
                    n_f_run  = 1'b0;
                    n_f_run2 = 1'b0;
                    n_state  = pick(1'b0, r_f_lit, r_f_push, 1'b0);
                end
            end
            S_HDR: begin
                pk_cmd.valid = 1'b1;
                pk_cmd.k     = KCNT_W'(1);
                pk_cmd.data  = {{(WORD_W-BYTE_W){1'b0}}, BYTE_W'(r_cnt - 1'b1)};
                if (pk_ready) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // one row of literals per cycle from the chain head, while the packer is ready
                pk_cmd.valid = 1'b1;
                pk_cmd.k     = (r_cnt > CNT_W'(WORD_BYTES)) ? KCNT_W'(WORD_BYTES)
                                                            : r_cnt[KCNT_W-1:0];
                pk_cmd.data  = ch_head;
                if (pk_ready) begin
                    ch_ctl.shift_en = 1'b1;
                    n_cnt = r_cnt - CNT_W'(pk_cmd.k);
                    if (r_cnt <= CNT_W'(WORD_BYTES)) begin
                        n_f_lit = 1'b0;
                        n_state = pick(1'b0, 1'b0, r_f_push, r_f_run2);
                    end
                end
            end
            S_PUSH: begin
                ch_ctl.wr_en   = 1'b1;
                ch_ctl.wr_idx  = r_cnt;
                ch_ctl.wr_byte = r_p2;
                n_cnt          = r_cnt + 1'b1;
                n_f_push       = 1'b0;
                n_state        = S_HDR;
            end
            S_FLUSH: begin
                pk_cmd.valid    = 1'b1;
                pk_cmd.flush    = 1'b1;
                pk_cmd.end_flag = r_end;
                if (pk_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_held    <= '0;
            r_held_v  <= 1'b0;
            r_run_len <= '0;
            r_run_act <= 1'b0;
            r_cnt     <= '0;
            r_f_run   <= 1'b0;
            r_f_lit   <= 1'b0;
            r_f_push  <= 1'b0;
            r_f_run2  <= 1'b0;
            r_end     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_held    <= n_held;
            r_held_v  <= n_held_v;
            r_run_len <= n_run_len;
            r_run_act <= n_run_act;
            r_cnt     <= n_cnt;
            r_f_run   <= n_f_run;
            r_f_lit   <= n_f_lit;
            r_f_push  <= n_f_push;
            r_f_run2  <= n_f_run2;
            r_end     <= n_end;
        end
    end

    // payload of pending emissions
    always_ff @(posedge i_clk) begin
        r_er_val <= n_er_val;
        r_er_len <= n_er_len;
        r_p2     <= n_p2;
    end

    pbr_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (ch_ctl),
        .o_head (ch_head)
    );

    pbr_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (pk_cmd),
        .o_ready     (pk_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    // a full literal group never survives to the next item
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_cnt < CNT_W'(MAX_BLOCK)))
        else $error("literal count full while idle");

    // an open run has a held byte and a legal length
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_act |-> (r_held_v && r_run_len >= CNT_W'(2)
                       && r_run_len <= CNT_W'(MAX_BLOCK)))
        else $error("open run with bad length");

    // drain only with literals in the chain
    a_drain_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_cnt != '0))
        else $error("drain with empty chain");

    // a run is emitted either before or after the literals, never both
    a_run_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_run |-> !r_f_run2)
        else $error("both run emissions pending");
`endif

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the PackBits run-length encoder: byte items in,
// packed encoded words out, compared with an in-bench predictor.
// Depends on pbr_pkg and packbits_run_length_encoder_unit.
module testbench;
    import pbr_pkg::*;

    localparam int ITEMS      = 430;      // input bytes to send
    localparam int HOLD_AT    = 200;      // sender waits for a full drain here
    localparam int PHASE_LEN  = 40;       // accepted items per idling phase
    localparam int LIMIT      = 400000;   // timeout in clock cycles
    localparam int TAIL       = 16;       // quiet cycles checked at the end

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // Stimulus and expectations
    t_in_item   pend_items[$];
    t_out_item  expected_words[$];
    logic [7:0] last_gen = 8'h00;
    int         accepted_cnt = 0;
    int         fail_cnt = 0;
    int         cycle_cnt = 0;
    bit         hold_done = 1'b0;

    // Predictor state
    logic [7:0] lit_bytes[MAX_BLOCK];
    int         lit_cnt = 0;
    logic [7:0] cur_byte = 8'h00;
    bit         cur_valid = 1'b0;
    int         rep_len = 0;
    bit         rep_open = 1'b0;
    logic [7:0] step_bytes[$];

    packbits_run_length_encoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    // Run header (1 - length) and the repeated value
    function automatic void close_repeat();
        step_bytes = {step_bytes, 8'(257 - rep_len)};
        step_bytes = {step_bytes, cur_byte};
        rep_open = 1'b0;
        rep_len  = 0;
    endfunction

    // Literal header (count - 1) and the stored bytes
    function automatic void flush_literals();
        if (lit_cnt == 0)
            return;
        step_bytes = {step_bytes, 8'(lit_cnt - 1)};
        for (int k = 0; k < lit_cnt; k++)
            step_bytes = {step_bytes, lit_bytes[k]};
        lit_cnt = 0;
    endfunction

    function automatic void add_literal(input logic [7:0] b);
        lit_bytes[lit_cnt] = b;
        lit_cnt++;
        if (lit_cnt >= MAX_BLOCK)
            flush_literals();
    endfunction

    // Encode one accepted byte and queue the words it produces
    function automatic void encode_byte(input t_in_item it);
        int        nw;
        int        cnt;
        t_out_item w;
        step_bytes.delete();
        if (!cur_valid) begin
            cur_byte  = it.byte_in;
            cur_valid = 1'b1;
        end else if (rep_open) begin
            if (it.byte_in == cur_byte && rep_len < MAX_BLOCK) begin
                rep_len++;
            end else begin
                close_repeat();
                cur_byte = it.byte_in;
            end
        end else if (it.byte_in == cur_byte) begin
            flush_literals();
            rep_open = 1'b1;
            rep_len  = 2;
        end else begin
            add_literal(cur_byte);
            cur_byte = it.byte_in;
        end

        // End of stream: flush everything and start over
        if (it.last_byte) begin
            if (rep_open) begin
                close_repeat();
            end else if (cur_valid) begin
                add_literal(cur_byte);
                flush_literals();
            end else begin
                flush_literals();
            end
            lit_cnt   = 0;
            cur_byte  = 8'h00;
            cur_valid = 1'b0;
            rep_len   = 0;
            rep_open  = 1'b0;
        end

        nw = (step_bytes.size() + 7) / 8;
        for (int k = 0; k < nw; k++) begin
            cnt = step_bytes.size() - k * 8;
            if (cnt > 8)
                cnt = 8;
            w = '0;
            for (int j = 0; j < cnt; j++)
                w.out_word[8*j +: 8] = step_bytes[k*8 + j];
            w.byte_count = KCNT_W'(cnt);
            w.step_last  = (k + 1 == nw);
            w.stream_end = it.last_byte && (k + 1 == nw);
            expected_words = {expected_words, w};
        end
    endfunction

    // Idle or stall percentage for the current phase
    function automatic int idle_pct(input bit receiver);
        case ((accepted_cnt / PHASE_LEN) % 4)
            1: return receiver ? 0 : 59;
            2: return receiver ? 59 : 0;
            3: return 23;
            default: return 0;
        endcase
    endfunction

    task automatic queue_byte(input logic [7:0] b, input bit last);
        pend_items = {pend_items, t_in_item'{b, last}};
        last_gen = b;
    endtask

    task automatic queue_run(input logic [7:0] b, input int n);
        repeat (n) queue_byte(b, 1'b0);
    endtask

    // Bytes that each differ from the one before
    task automatic queue_literals(input int n);
        repeat (n) queue_byte(last_gen ^ 8'($urandom_range(1, 255)), 1'b0);
    endtask

    task automatic mark_end();
        pend_items[pend_items.size() - 1].last_byte = 1'b1;
    endtask

    // Driver: predicts on acceptance, then presents the next item
    always @(posedge i_clk) begin : drive_bytes
        bit drain_wait;
        bit send;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                encode_byte(i_in_item);
                accepted_cnt++;
            end
            if (i_in_valid && !o_in_ready) begin
                i_in_valid <= 1'b1;
            end else begin
                drain_wait = (accepted_cnt >= HOLD_AT) && !hold_done;
                if (drain_wait && expected_words.size() == 0)
                    hold_done = 1'b1;
                send = !drain_wait && pend_items.size() > 0 &&
                       ($urandom_range(99) >= idle_pct(1'b0));
                if (send)
                    i_in_item <= pend_items.pop_front();
                i_in_valid <= send;
            end
        end
    end

    // Monitor: compares each accepted word with the oldest expectation
    always @(posedge i_clk) begin : check_words
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word: expected none, got %h",
                             $time, o_out_item);
                    fail_cnt++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_out_item.out_word !== want.out_word) begin
                        $display("%0t: out_word expected %h got %h",
                                 $time, want.out_word, o_out_item.out_word);
                        fail_cnt++;
                    end
                    if (o_out_item.byte_count !== want.byte_count) begin
                        $display("%0t: byte_count expected %0d got %0d",
                                 $time, want.byte_count, o_out_item.byte_count);
                        fail_cnt++;
                    end
                    if (o_out_item.step_last !== want.step_last) begin
                        $display("%0t: step_last expected %b got %b",
                                 $time, want.step_last, o_out_item.step_last);
                        fail_cnt++;
                    end
                    if (o_out_item.stream_end !== want.stream_end) begin
                        $display("%0t: stream_end expected %b got %b",
                                 $time, want.stream_end, o_out_item.stream_end);
                        fail_cnt++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        int         kind;
        logic [7:0] v;

        // Directed: single-byte streams at both extremes
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        // Short run, steps that emit nothing until the end
        queue_run(8'h55, 2);
        queue_byte(8'h55, 1'b1);
        // Literals, then a byte equal to the pending one opens a run
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h34, 1'b0);
        queue_run(8'h34, 2);
        queue_byte(8'h56, 1'b1);
        // Run broken by a literal, then last byte opens nothing new
        queue_byte(8'h01, 1'b0);
        queue_run(8'h02, 2);
        queue_byte(8'h03, 1'b1);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7F, 1'b1);
        // Last byte closes a run of two
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'hC3, 1'b1);

        // Literal group past full size, then a run past its limit
        queue_literals(130);
        v = last_gen ^ 8'h5A;
        queue_run(v, 131);
        queue_byte(v ^ 8'h01, 1'b1);

        // Random streams built from runs, literal groups and noise
        while (pend_items.size() < ITEMS) begin
            repeat ($urandom_range(1, 6)) begin
                kind = $urandom_range(0, 3);
                case (kind)
                    0: queue_run(8'($urandom), $urandom_range(2, 9));
                    1: queue_literals($urandom_range(1, 9));
                    2: begin
                        v = 8'($urandom);
                        repeat ($urandom_range(1, 6))
                            queue_byte(v ^ 8'($urandom_range(0, 1)), 1'b0);
                    end
                    default: queue_byte(8'($urandom), 1'b0);
                endcase
            end
            mark_end();
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all items to be taken, then for all words
        while (pend_items.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
